// ----- design/bfba_pkg.sv -----
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared constants for the best-fit bin allocator: parameter defaults,
// configuration reset value and result status codes.
// ----------------------------------------------------------------------------
package bfba_pkg;

  // parameter defaults
  localparam int unsigned MAX_BINS_DEF  = 64;
  localparam int unsigned SIZE_BITS_DEF = 16;

  // reset value of the bin capacity register
  localparam int unsigned CAP_RESET = 100;

  // result status codes
  localparam logic [1:0] STAT_PLACED   = 2'd0;
  localparam logic [1:0] STAT_OVERSIZE = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

endpackage

// ----- design/best_fit_bin_allocator.sv -----
// ----------------------------------------------------------------------------
// best_fit_bin_allocator
// Online best-fit bin packing over a row of bin cells with a search token.
// ----------------------------------------------------------------------------
// An item that fits capacity is registered and the search token walks the
// cell row (one cell per cycle) before placement is decided and registered
// as the result; an oversized item skips the walk. One item at a time: a new
// item is taken only once the last item's result has been registered.
// Reset clears the bin count and loads bin capacity 100; bin space is not
// cleared, a bin's entry is written when it is opened.
module best_fit_bin_allocator #(
  parameter int unsigned MAX_BINS  = bfba_pkg::MAX_BINS_DEF,
  parameter int unsigned SIZE_BITS = bfba_pkg::SIZE_BITS_DEF,
  localparam int unsigned IDX_W    = $clog2(MAX_BINS),
  localparam int unsigned CNT_W    = $clog2(MAX_BINS + 1),
  localparam int unsigned IN_W     = ((SIZE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = IDX_W + 1 + CNT_W + SIZE_BITS + 2,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write: bin_capacity
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [SIZE_BITS-1:0] cfg_data_i,
  // item input
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [IN_W-1:0]      s_axis_tdata_i,  // item_size
  // result output
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OUT_W-1:0]     m_axis_tdata_o   // bin_index, opened_new, bins_used,
                                                // space_left, status
);

  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [IDX_W-1:0]     best_idx;
    logic [SIZE_BITS-1:0] best_left;
  } tok_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] item;
    logic [CNT_W-1:0]     count;
  } ctx_t;

  typedef struct packed {
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [SIZE_BITS-1:0] wr_data;
  } upd_t;

  tok_t                 tok_w [MAX_BINS+1];
  ctx_t                 ctx;
  upd_t                 upd;
  logic [IDX_W-1:0]     bin_index;
  logic                 opened_new;
  logic [CNT_W-1:0]     bins_used;
  logic [SIZE_BITS-1:0] space_left;
  logic [1:0]           status;

  // sequencer and result register
  bfba_ctrl #(
    .MAX_BINS (MAX_BINS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W),
    .SIZE_BITS(SIZE_BITS),
    .tok_t    (tok_t),
    .ctx_t    (ctx_t),
    .upd_t    (upd_t)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_cap_i   (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .item_i      (s_axis_tdata_i[SIZE_BITS-1:0]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .bin_index_o (bin_index),
    .opened_new_o(opened_new),
    .bins_used_o (bins_used),
    .space_left_o(space_left),
    .status_o    (status),
    .ctx_o       (ctx),
    .upd_o       (upd),
    .tok_o       (tok_w[0]),
    .tok_i       (tok_w[MAX_BINS])
  );

  // row of bin cells
  for (genvar k = 0; k < MAX_BINS; k++) begin : g_cell
    bfba_cell #(
      .IDX      (k),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .SIZE_BITS(SIZE_BITS),
      .tok_t    (tok_t),
      .ctx_t    (ctx_t),
      .upd_t    (upd_t)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctx_i (ctx),
      .upd_i (upd),
      .tok_i (tok_w[k]),
      .tok_o (tok_w[k+1])
    );
  end

  // pack result fields, zero fill to whole bytes
  always_comb begin
    m_axis_tdata_o                 = '0;
    m_axis_tdata_o[OUT_BITS-1:0]   = {status, space_left, bins_used, opened_new, bin_index};
  end

endmodule

// ----- design/bfba_cell.sv -----
// ----------------------------------------------------------------------------
// bfba_cell
// One bin of the allocator. Holds the bin's remaining space, refines the
// best-fit search token as it passes by and hands it to the next cell.
// ----------------------------------------------------------------------------
module bfba_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned IDX_W     = 6,
  parameter int unsigned CNT_W     = 7,
  parameter int unsigned SIZE_BITS = 16,
  parameter type         tok_t     = logic,
  parameter type         ctx_t     = logic,
  parameter type         upd_t     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  ctx_t ctx_i,
  input  upd_t upd_i,
  input  tok_t tok_i,
  output tok_t tok_o
);

  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [SIZE_BITS-1:0] space_q;
  logic [SIZE_BITS-1:0] left;
  logic                 is_open;
  logic                 fits;
  logic                 better;
  tok_t                 tok_d;
  tok_t                 tok_q;

  // compare this bin against the best candidate so far
  always_comb begin
    is_open = MY_CNT < ctx_i.count;
    fits    = space_q >= ctx_i.item;
    left    = space_q - ctx_i.item;
    better  = tok_i.valid && is_open && fits &&
              (!tok_i.found || (left < tok_i.best_left));
    tok_d   = tok_i;
    if (better) begin
      tok_d.found     = 1'b1;
      tok_d.best_idx  = MY_IDX;
      tok_d.best_left = left;
    end
  end

  // search token register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // bin space, written when this bin is chosen or opened
  always_ff @(posedge clk_i) begin
    if (upd_i.wr_en && (upd_i.wr_idx == MY_IDX)) begin
      space_q <= upd_i.wr_data;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- design/bfba_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfba_ctrl
// Sequencer of the allocator: takes items, launches the search token into
// the cell row, decides placement, updates the bin count and the chosen
// cell, and holds the result register.
// ----------------------------------------------------------------------------
module bfba_ctrl #(
  parameter int unsigned MAX_BINS  = 64,
  parameter int unsigned IDX_W     = 6,
  parameter int unsigned CNT_W     = 7,
  parameter int unsigned SIZE_BITS = 16,
  parameter type         tok_t     = logic,
  parameter type         ctx_t     = logic,
  parameter type         upd_t     = logic
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [SIZE_BITS-1:0] cfg_cap_i,
  // item input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SIZE_BITS-1:0] item_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IDX_W-1:0]     bin_index_o,
  output logic                 opened_new_o,
  output logic [CNT_W-1:0]     bins_used_o,
  output logic [SIZE_BITS-1:0] space_left_o,
  output logic [1:0]           status_o,
  // cell row
  output ctx_t                 ctx_o,
  output upd_t                 upd_o,
  output tok_t                 tok_o,
  input  tok_t                 tok_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_BINS);

  logic [1:0]           state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [SIZE_BITS-1:0] cap_q;
  logic [SIZE_BITS-1:0] item_q;
  logic                 ovs_q;
  logic                 start_q;
  logic                 out_valid_q;
  tok_t                 res_q;

  logic                 accept;
  logic                 oversize;
  logic                 out_free;
  logic                 done_fire;
  logic                 full;

  logic [IDX_W-1:0]     idx_d;
  logic                 new_d;
  logic [SIZE_BITS-1:0] left_d;
  logic [1:0]           stat_d;

  logic [IDX_W-1:0]     idx_q;
  logic                 new_q;
  logic [CNT_W-1:0]     used_q;
  logic [SIZE_BITS-1:0] left_q;
  logic [1:0]           stat_q;

  // handshake helpers
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign oversize    = item_i > cap_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign done_fire   = (state_q == ST_DONE) && out_free;
  assign full        = (count_q == FULL_CNT);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = oversize ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_i.valid) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // placement decision at the end of the search
  always_comb begin
    idx_d         = '0;
    new_d         = 1'b0;
    left_d        = '0;
    stat_d        = bfba_pkg::STAT_PLACED;
    count_d       = count_q;
    upd_o.wr_en   = 1'b0;
    upd_o.wr_idx  = '0;
    upd_o.wr_data = '0;
    if (ovs_q) begin
      stat_d = bfba_pkg::STAT_OVERSIZE;
    end else if (res_q.found) begin
      idx_d  = res_q.best_idx;
      left_d = res_q.best_left;
    end else if (full) begin
      stat_d = bfba_pkg::STAT_FULL;
    end else begin
      idx_d   = count_q[IDX_W-1:0];
      new_d   = 1'b1;
      left_d  = cap_q - item_q;
      count_d = count_q + CNT_W'(1);
    end
    if (done_fire && !ovs_q && (res_q.found || !full)) begin
      upd_o.wr_en   = 1'b1;
      upd_o.wr_idx  = idx_d;
      upd_o.wr_data = left_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cap_q       <= SIZE_BITS'(bfba_pkg::CAP_RESET);
      start_q     <= 1'b0;
      ovs_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= accept && !oversize;
      if (cfg_valid_i) begin
        cap_q <= cfg_cap_i;
      end
      if (accept) begin
        ovs_q <= oversize;
      end
      if (done_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item, search result and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if ((state_q == ST_SCAN) && tok_i.valid) begin
      res_q <= tok_i;
    end
    if (done_fire) begin
      idx_q  <= idx_d;
      new_q  <= new_d;
      used_q <= count_d;
      left_q <= left_d;
      stat_q <= stat_d;
    end
  end

  // search context and token launched into the first cell
  assign ctx_o.item      = item_q;
  assign ctx_o.count     = count_q;
  assign tok_o.valid     = start_q;
  assign tok_o.found     = 1'b0;
  assign tok_o.best_idx  = '0;
  assign tok_o.best_left = '0;

  assign out_valid_o  = out_valid_q;
  assign bin_index_o  = idx_q;
  assign opened_new_o = new_q;
  assign bins_used_o  = used_q;
  assign space_left_o = left_q;
  assign status_o     = stat_q;

  // bin count never passes the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("bin count exceeds table size");

  // the token leaves the row only while a search is running
  a_tok_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_i.valid |-> (state_q == ST_SCAN))
    else $error("search token outside of scan");

  // opening a bin bumps the count by one
  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && !ovs_q && !res_q.found && !full) |=>
      (count_q == $past(count_q) + CNT_W'(1)))
    else $error("bin count not advanced on open");

  // a result is produced only after a search or an oversize item
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result without finished placement");

endmodule
